FILE: rtl/core/hrlp_pkg.sv
`timescale 1ns / 1ps
// Package for the HTTP request line parser: types, codes, limits and the method name table.
// Used by hrlp_step and http_request_line_parser_top. Has no dependencies of its own.
package hrlp_pkg;

    localparam int MAX_LINE      = 8192;
    localparam int MAX_FIELD     = 4096;
    localparam int VERSION_CHARS = 8;

    localparam int POS_W = 13;
    localparam int CNT_W = 12;
    localparam int CAP_W = 13;
    localparam int VCNT_W = 4;
    localparam int VIDX_W = 3;

    localparam int POS_CAP_I   = ((MAX_LINE - 1) < 8191) ? (MAX_LINE - 1) : 8191;
    localparam int FIELD_CAP_I = (MAX_FIELD < 4096) ? MAX_FIELD : 4096;

    localparam logic [POS_W-1:0] POS_CAP   = POS_W'(POS_CAP_I);
    localparam logic [CAP_W-1:0] FIELD_CAP = CAP_W'(FIELD_CAP_I);
    localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    typedef enum logic [0:0] {
        REG_PATH_CAP  = 1'b0,
        REG_QUERY_CAP = 1'b1
    } t_reg_index;

    typedef enum logic [3:0] {
        PH_METHOD  = 4'b0001,
        PH_URI     = 4'b0010,
        PH_VERSION = 4'b0100,
        PH_SKIP    = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        VERDICT_OK      = 2'd0,
        VERDICT_BAD     = 2'd1,
        VERDICT_LONG    = 2'd2,
        VERDICT_VERSION = 2'd3
    } t_verdict;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_PATH  = 2'd1,
        KIND_QUERY = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        METHOD_GET    = 2'd0,
        METHOD_POST   = 2'd1,
        METHOD_PUT    = 2'd2,
        METHOD_DELETE = 2'd3
    } t_method;

    typedef logic [VERSION_CHARS-1:0][7:0] t_ver_bytes;

    typedef struct packed {
        logic [CAP_W-1:0] path_cap;
        logic [CAP_W-1:0] query_cap;
    } t_cfg;

    typedef struct packed {
        t_phase             phase;
        logic [POS_W-1:0]   pos;
        logic [3:0]         cand;
        logic [2:0]         mlen;
        logic [POS_W-1:0]   uri_start;
        logic               first_seen;
        logic               qmode;
        logic [CNT_W-1:0]   path_cnt;
        logic [CNT_W-1:0]   query_cnt;
        logic [1:0]         esc_rem;
        logic               esc_long;
        logic               pend_valid;
        t_verdict           pend_code;
        logic [POS_W-1:0]   pend_pos;
        t_verdict           err_code;
        logic [POS_W-1:0]   err_pos;
        logic [VCNT_W-1:0]  ver_cnt;
    } t_state;

    typedef struct packed {
        t_kind              data_kind;
        logic [7:0]         data_byte;
        logic [CNT_W-1:0]   data_index;
        logic               line_done;
        t_verdict           verdict;
        t_method            method_code;
        logic               version_major;
        logic [3:0]         version_minor;
        logic [CNT_W-1:0]   path_length;
        logic [CNT_W-1:0]   query_length;
        logic [POS_W-1:0]   error_position;
    } t_result;

    localparam t_state LINE_RESET = '{
        phase:      PH_METHOD,
        pos:        '0,
        cand:       4'b1111,
        mlen:       '0,
        uri_start:  '0,
        first_seen: 1'b0,
        qmode:      1'b0,
        path_cnt:   '0,
        query_cnt:  '0,
        esc_rem:    '0,
        esc_long:   1'b0,
        pend_valid: 1'b0,
        pend_code:  VERDICT_OK,
        pend_pos:   '0,
        err_code:   VERDICT_OK,
        err_pos:    '0,
        ver_cnt:    '0
    };

    function automatic logic [2:0] meth_len(input logic [1:0] k);
        logic [2:0] l;
        unique case (k)
            METHOD_GET:    l = 3'd3;
            METHOD_POST:   l = 3'd4;
            METHOD_PUT:    l = 3'd3;
            METHOD_DELETE: l = 3'd6;
            default:       l = 3'd3;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] meth_char(input logic [1:0] k, input logic [2:0] i);
        logic [47:0] s;
        logic [7:0]  c;
        unique case (k)
            METHOD_GET:    s = {"GET", 24'd0};
            METHOD_POST:   s = {"POST", 16'd0};
            METHOD_PUT:    s = {"PUT", 24'd0};
            METHOD_DELETE: s = "DELETE";
            default:       s = '0;
        endcase
        unique case (i)
            3'd0:    c = s[47:40];
            3'd1:    c = s[39:32];
            3'd2:    c = s[31:24];
            3'd3:    c = s[23:16];
            3'd4:    c = s[15:8];
            3'd5:    c = s[7:0];
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] r);
        logic [CAP_W-1:0] v;
        if (r < CAP_MIN) begin
            v = CAP_MIN;
        end else if (r > FIELD_CAP) begin
            v = FIELD_CAP;
        end else begin
            v = r;
        end
        return v;
    endfunction

    function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
        return (p < POS_CAP) ? p + POS_W'(1) : POS_CAP;
    endfunction

endpackage

FILE: rtl/core/http_request_line_parser_top.sv
`timescale 1ns / 1ps
// The result for a byte is shown in the cycle after its transaction, from an output register.
// Throughput: one byte per cycle; a new byte is taken while a result waits, as long as the
// output register is empty or being emptied in the same cycle, so the rate is set by the sink.
// Reset (synchronous, active low) returns the line state to the method phase, empties the
// output register and sets both capacities to 1024. No clearing pass is needed.
// Top level of the HTTP request line parser; depends on hrlp_pkg and hrlp_step.
module http_request_line_parser_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_line_byte,
    input  logic                            i_line_last,

    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_data_kind,
    output logic [7:0]                      o_data_byte,
    output logic [11:0]                     o_data_index,
    output logic                            o_line_done,
    output logic [1:0]                      o_verdict,
    output logic [1:0]                      o_method_code,
    output logic                            o_version_major,
    output logic [3:0]                      o_version_minor,
    output logic [11:0]                     o_path_length,
    output logic [11:0]                     o_query_length,
    output logic [12:0]                     o_error_position,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hrlp_pkg::ADDR_W-1:0]     paddr,
    input  logic [hrlp_pkg::DATA_W-1:0]     pwdata,
    output logic [hrlp_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    hrlp_pkg::t_state       r_state;
    hrlp_pkg::t_state       n_state;
    hrlp_pkg::t_ver_bytes   r_ver;
    hrlp_pkg::t_ver_bytes   n_ver;
    hrlp_pkg::t_result      r_out;
    hrlp_pkg::t_result      n_out;
    logic                   r_out_valid;
    logic [hrlp_pkg::CAP_W-1:0] r_path_cap;
    logic [hrlp_pkg::CAP_W-1:0] r_query_cap;
    hrlp_pkg::t_cfg         cfg;
    hrlp_pkg::t_reg_index   reg_sel;
    logic                   in_take;
    logic                   cfg_write;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_take    = i_in_valid && o_in_ready;

    assign pready    = 1'b1;
    assign reg_sel   = hrlp_pkg::t_reg_index'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        unique case (reg_sel)
            hrlp_pkg::REG_PATH_CAP:  prdata = hrlp_pkg::DATA_W'(r_path_cap);
            hrlp_pkg::REG_QUERY_CAP: prdata = hrlp_pkg::DATA_W'(r_query_cap);
            default:                 prdata = '0;
        endcase
    end

    assign cfg.path_cap  = r_path_cap;
    assign cfg.query_cap = r_query_cap;

    hrlp_step u_step (
        .i_state  (r_state),
        .i_ver    (r_ver),
        .i_cfg    (cfg),
        .i_byte   (i_line_byte),
        .i_last   (i_line_last),
        .o_state  (n_state),
        .o_ver    (n_ver),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hrlp_pkg::LINE_RESET;
            r_out_valid <= 1'b0;
            r_path_cap  <= hrlp_pkg::CAP_RESET;
            r_query_cap <= hrlp_pkg::CAP_RESET;
        end else begin
            if (in_take) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_write && reg_sel == hrlp_pkg::REG_PATH_CAP) begin
                r_path_cap <= pwdata[hrlp_pkg::CAP_W-1:0];
            end
            if (cfg_write && reg_sel == hrlp_pkg::REG_QUERY_CAP) begin
                r_query_cap <= pwdata[hrlp_pkg::CAP_W-1:0];
            end
        end
    end

    // Version bytes and the result payload carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ver <= n_ver;
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_data_kind      = r_out.data_kind;
    assign o_data_byte      = r_out.data_byte;
    assign o_data_index     = r_out.data_index;
    assign o_line_done      = r_out.line_done;
    assign o_verdict        = r_out.verdict;
    assign o_method_code    = r_out.method_code;
    assign o_version_major  = r_out.version_major;
    assign o_version_minor  = r_out.version_minor;
    assign o_path_length    = r_out.path_length;
    assign o_query_length   = r_out.query_length;
    assign o_error_position = r_out.error_position;

endmodule

FILE: rtl/core/hrlp_step.sv
`timescale 1ns / 1ps
// Per-byte parser logic: next line state and the result for one byte of the request line.
// Purely combinational; depends on hrlp_pkg.
module hrlp_step (
    input  hrlp_pkg::t_state            i_state,
    input  hrlp_pkg::t_ver_bytes        i_ver,
    input  hrlp_pkg::t_cfg              i_cfg,
    input  logic [7:0]                  i_byte,
    input  logic                        i_last,
    output hrlp_pkg::t_state            o_state,
    output hrlp_pkg::t_ver_bytes        o_ver,
    output hrlp_pkg::t_result           o_result
);

    always_comb begin
        hrlp_pkg::t_state           st;
        hrlp_pkg::t_state           nx;
        hrlp_pkg::t_ver_bytes       ver;
        hrlp_pkg::t_result          res;
        logic [hrlp_pkg::POS_W-1:0] pos;
        logic [hrlp_pkg::POS_W-1:0] back;
        logic [hrlp_pkg::POS_W-1:0] pct;
        logic [hrlp_pkg::CNT_W-1:0] len;
        logic [hrlp_pkg::CAP_W-1:0] cap_m1;
        logic [1:0]                 esc_dec;
        logic                       commit_en;
        hrlp_pkg::t_verdict         commit_code;
        logic [hrlp_pkg::POS_W-1:0] commit_pos;
        logic                       hold_en;
        hrlp_pkg::t_verdict         hold_code;
        logic [hrlp_pkg::POS_W-1:0] hold_pos;
        logic                       do_echo;
        logic                       echo_query;
        logic                       hit;
        logic [1:0]                 hit_k;
        logic                       ver_ok;

        st  = i_state;
        nx  = i_state;
        ver = i_ver;
        res = '0;
        pos = st.pos;

        back = hrlp_pkg::POS_W'(2'd3 - st.esc_rem);
        pct  = (pos >= back) ? pos - back : '0;

        len    = st.qmode ? st.query_cnt : st.path_cnt;
        cap_m1 = hrlp_pkg::eff_cap(st.qmode ? i_cfg.query_cap : i_cfg.path_cap)
                 - hrlp_pkg::CAP_W'(1);

        esc_dec     = st.esc_rem - 2'd1;
        commit_en   = 1'b0;
        commit_code = hrlp_pkg::VERDICT_BAD;
        commit_pos  = '0;
        hold_en     = 1'b0;
        hold_code   = hrlp_pkg::VERDICT_BAD;
        hold_pos    = '0;
        do_echo     = 1'b0;
        echo_query  = st.qmode;
        hit         = 1'b0;
        hit_k       = '0;
        ver_ok      = 1'b0;

        unique case (st.phase)
            hrlp_pkg::PH_METHOD: begin
                if (i_byte == " ") begin
                    // The lowest-numbered live candidate of matching length wins.
                    for (int k = 3; k >= 0; k--) begin
                        if (st.cand[k] && st.mlen == hrlp_pkg::meth_len(2'(k))) begin
                            hit   = 1'b1;
                            hit_k = 2'(k);
                        end
                    end
                    if (st.mlen == '0 || !hit) begin
                        commit_en = 1'b1;
                    end else begin
                        nx.cand      = 4'b0001 << hit_k;
                        nx.phase     = hrlp_pkg::PH_URI;
                        nx.uri_start = hrlp_pkg::pos_inc(pos);
                    end
                end else begin
                    for (int k = 0; k < 4; k++) begin
                        if (st.mlen >= hrlp_pkg::meth_len(2'(k)) ||
                            hrlp_pkg::meth_char(2'(k), st.mlen) != i_byte) begin
                            nx.cand[k] = 1'b0;
                        end
                    end
                    if (st.mlen != 3'd7) begin
                        nx.mlen = st.mlen + 3'd1;
                    end
                end
            end
            hrlp_pkg::PH_URI: begin
                if (i_byte == " ") begin
                    if (st.pend_valid) begin
                        commit_en   = 1'b1;
                        commit_code = st.pend_code;
                        commit_pos  = st.pend_pos;
                    end else if (!st.first_seen) begin
                        commit_en  = 1'b1;
                        commit_pos = st.uri_start;
                    end else if (st.esc_rem != '0) begin
                        commit_en  = 1'b1;
                        commit_pos = pct;
                    end else begin
                        nx.phase     = hrlp_pkg::PH_VERSION;
                        nx.uri_start = hrlp_pkg::pos_inc(pos);
                        nx.ver_cnt   = '0;
                    end
                end else if (st.pend_valid) begin
                    // A held error only waits for the closing space.
                end else if (st.esc_rem != '0) begin
                    if (!hrlp_pkg::is_hex(i_byte)) begin
                        hold_en  = 1'b1;
                        hold_pos = pct;
                    end else begin
                        nx.esc_rem = esc_dec;
                        if (!st.esc_long) begin
                            do_echo = 1'b1;
                        end else if (esc_dec == '0) begin
                            hold_en   = 1'b1;
                            hold_code = hrlp_pkg::VERDICT_LONG;
                            hold_pos  = pct;
                        end
                    end
                end else if (!st.first_seen && i_byte != "/") begin
                    nx.first_seen = 1'b1;
                    hold_en       = 1'b1;
                    hold_pos      = st.uri_start;
                end else begin
                    nx.first_seen = 1'b1;
                    if (i_byte < 8'h20 || i_byte >= 8'h7F || i_byte == "#") begin
                        hold_en  = 1'b1;
                        hold_pos = pos;
                    end else if (!st.qmode && i_byte == "?") begin
                        // The question mark opens the query and is stored with no size check.
                        nx.qmode   = 1'b1;
                        do_echo    = 1'b1;
                        echo_query = 1'b1;
                    end else if ({1'b0, len} >= cap_m1) begin
                        hold_en   = 1'b1;
                        hold_code = hrlp_pkg::VERDICT_LONG;
                        hold_pos  = pos;
                    end else if (i_byte == "%") begin
                        nx.esc_rem  = 2'd2;
                        nx.esc_long = ({1'b0, len} + hrlp_pkg::CAP_W'(3)) > cap_m1;
                        do_echo     = !nx.esc_long;
                    end else begin
                        do_echo = 1'b1;
                    end
                end
            end
            hrlp_pkg::PH_VERSION: begin
                if (st.ver_cnt < 4'(hrlp_pkg::VERSION_CHARS)) begin
                    ver[st.ver_cnt[hrlp_pkg::VIDX_W-1:0]] = i_byte;
                end
                if (st.ver_cnt < 4'(hrlp_pkg::VERSION_CHARS + 1)) begin
                    nx.ver_cnt = st.ver_cnt + 4'd1;
                end
            end
            hrlp_pkg::PH_SKIP: begin
            end
            default: begin
            end
        endcase

        if (hold_en) begin
            nx.pend_valid = 1'b1;
            nx.pend_code  = hold_code;
            nx.pend_pos   = hold_pos;
            nx.esc_rem    = '0;
        end
        if (commit_en) begin
            nx.err_code = commit_code;
            nx.err_pos  = commit_pos;
            nx.phase    = hrlp_pkg::PH_SKIP;
        end

        if (do_echo) begin
            res.data_byte = i_byte;
            if (echo_query) begin
                res.data_kind  = hrlp_pkg::KIND_QUERY;
                res.data_index = nx.query_cnt;
                nx.query_cnt   = nx.query_cnt + hrlp_pkg::CNT_W'(1);
            end else begin
                res.data_kind  = hrlp_pkg::KIND_PATH;
                res.data_index = nx.path_cnt;
                nx.path_cnt    = nx.path_cnt + hrlp_pkg::CNT_W'(1);
            end
        end

        nx.pos = hrlp_pkg::pos_inc(pos);

        if (i_last) begin
            res.line_done = 1'b1;
            unique case (nx.phase)
                hrlp_pkg::PH_SKIP: begin
                    res.verdict        = nx.err_code;
                    res.error_position = nx.err_pos;
                end
                hrlp_pkg::PH_METHOD: begin
                    res.verdict = hrlp_pkg::VERDICT_BAD;
                end
                hrlp_pkg::PH_URI: begin
                    res.verdict        = hrlp_pkg::VERDICT_BAD;
                    res.error_position = nx.uri_start;
                end
                hrlp_pkg::PH_VERSION: begin
                    ver_ok = nx.ver_cnt == 4'(hrlp_pkg::VERSION_CHARS) &&
                             ver[0] == "H" && ver[1] == "T" && ver[2] == "T" &&
                             ver[3] == "P" && ver[4] == "/" &&
                             ver[5] >= "0" && ver[5] <= "9" && ver[6] == "." &&
                             ver[7] >= "0" && ver[7] <= "9";
                    if (!ver_ok) begin
                        res.verdict        = hrlp_pkg::VERDICT_BAD;
                        res.error_position = nx.uri_start;
                    end else if ((ver[5] == "0" && ver[7] == "9") ||
                                 (ver[5] == "1" && (ver[7] == "0" || ver[7] == "1"))) begin
                        // ASCII digits carry their value in the low nibble.
                        res.verdict       = hrlp_pkg::VERDICT_OK;
                        res.version_major = ver[5][0];
                        res.version_minor = ver[7][3:0];
                        res.path_length   = nx.path_cnt;
                        res.query_length  = nx.query_cnt;
                        priority if (nx.cand[0]) begin
                            res.method_code = hrlp_pkg::METHOD_GET;
                        end else if (nx.cand[1]) begin
                            res.method_code = hrlp_pkg::METHOD_POST;
                        end else if (nx.cand[2]) begin
                            res.method_code = hrlp_pkg::METHOD_PUT;
                        end else begin
                            res.method_code = hrlp_pkg::METHOD_DELETE;
                        end
                    end else begin
                        res.verdict        = hrlp_pkg::VERDICT_VERSION;
                        res.error_position = nx.uri_start;
                    end
                end
                default: begin
                    res.verdict = hrlp_pkg::VERDICT_BAD;
                end
            endcase
            nx = hrlp_pkg::LINE_RESET;
        end

        o_state  = nx;
        o_ver    = ver;
        o_result = res;
    end

endmodule
